>>> sv/gmb_pkg.sv
package gmb_pkg;

  localparam int MAX_SIDE  = 128;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int COORD_W   = $clog2(MAX_SIDE);
  localparam int IDX_W     = 2 * COORD_W;
  localparam int DEPTH_W   = IDX_W + 1;
  localparam int SIDE_W    = 8;

  localparam logic [4:0] B_TOP    = 5'd1;
  localparam logic [4:0] B_BOTTOM = 5'd2;
  localparam logic [4:0] B_LEFT   = 5'd4;
  localparam logic [4:0] B_RIGHT  = 5'd8;
  localparam logic [4:0] B_VISIT  = 5'd16;
  localparam logic [4:0] B_WALLS  = 5'd15;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WALK  = 2'd1,
    CMD_EXIT  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CARVED   = 3'd0,
    ST_BACK     = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EXIT_OK  = 3'd3,
    ST_EXIT_NO  = 3'd4,
    ST_READ     = 3'd5,
    ST_STARTED  = 3'd6
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CLEAR_END,
    S_EMPTY,
    S_STK_RD,
    S_STK_WAIT,
    S_NB_RD,
    S_PICK,
    S_CARVE_TOP,
    S_CARVE_NB,
    S_POP,
    S_XY_RD,
    S_XY_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    state_t op;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_take;
    logic depth_zero;
    logic clr_last;
    logic rd_last;
    logic has_nb;
    logic out_free;
  } sts_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  function automatic logic [1:0] mod_cnt(input logic [15:0] r, input logic [2:0] cnt);
    logic [31:0] prod;
    logic [15:0] q;
    logic [17:0] q3;
    logic [2:0]  rem;
    logic [1:0]  res;
    prod = 32'(r) * 32'd21845;
    q    = prod[31:16];
    q3   = 18'(q) * 18'd3;
    rem  = 3'(18'(r) - q3);
    if (rem >= 3'd3) rem = rem - 3'd3;
    case (cnt)
      3'd2:    res = {1'b0, r[0]};
      3'd3:    res = rem[1:0];
      3'd4:    res = r[1:0];
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

>>> sv/gmb_ctrl.sv
module gmb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  gmb_pkg::sts_t  sts,
  output gmb_pkg::ctl_t  ctl
);

  gmb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= gmb_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      gmb_pkg::S_IDLE: begin
        if (sts.in_take) begin
          case (sts.cmd)
            gmb_pkg::CMD_START: state_next = gmb_pkg::S_CLEAR;
            gmb_pkg::CMD_WALK:  state_next = sts.depth_zero ? gmb_pkg::S_EMPTY
                                                             : gmb_pkg::S_STK_RD;
            default:            state_next = gmb_pkg::S_XY_RD;
          endcase
        end
      end
      gmb_pkg::S_CLEAR:     if (sts.clr_last) state_next = gmb_pkg::S_CLEAR_END;
      gmb_pkg::S_CLEAR_END: state_next = gmb_pkg::S_DONE;
      gmb_pkg::S_EMPTY:     state_next = gmb_pkg::S_DONE;
      gmb_pkg::S_STK_RD:    state_next = gmb_pkg::S_STK_WAIT;
      gmb_pkg::S_STK_WAIT:  state_next = gmb_pkg::S_NB_RD;
      gmb_pkg::S_NB_RD:     if (sts.rd_last) state_next = gmb_pkg::S_PICK;
      gmb_pkg::S_PICK:      state_next = sts.has_nb ? gmb_pkg::S_CARVE_TOP : gmb_pkg::S_POP;
      gmb_pkg::S_CARVE_TOP: state_next = gmb_pkg::S_CARVE_NB;
      gmb_pkg::S_CARVE_NB:  state_next = gmb_pkg::S_DONE;
      gmb_pkg::S_POP:       state_next = gmb_pkg::S_DONE;
      gmb_pkg::S_XY_RD:     state_next = gmb_pkg::S_XY_EXEC;
      gmb_pkg::S_XY_EXEC:   state_next = gmb_pkg::S_DONE;
      gmb_pkg::S_DONE:      if (sts.out_free) state_next = gmb_pkg::S_IDLE;
      default:              state_next = gmb_pkg::S_IDLE;
    endcase
  end

  assign ctl.op = state;

endmodule

>>> sv/gmb_dp.sv
module gmb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gmb_pkg::ctl_t                 ctl,
  output gmb_pkg::sts_t                 sts,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [15:0]                   random_value,
  input  logic [gmb_pkg::COORD_W-1:0]   cell_x,
  input  logic [gmb_pkg::COORD_W-1:0]   cell_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [gmb_pkg::COORD_W-1:0]   pos_x,
  output logic [gmb_pkg::COORD_W-1:0]   pos_y,
  output logic                          wall_top,
  output logic                          wall_bottom,
  output logic                          wall_left,
  output logic                          wall_right,
  output logic                          cell_visited
);

  localparam int CW = gmb_pkg::COORD_W;
  localparam int IW = gmb_pkg::IDX_W;
  localparam int DW = gmb_pkg::DEPTH_W;
  localparam int SW = gmb_pkg::SIDE_W;

  logic [SW-1:0] grid_side;
  logic [2:0]    exit_limit;
  logic [SW-1:0] side;

  logic [4:0]    cell_mem [gmb_pkg::CELLS];
  logic [IW-1:0] stk_mem  [gmb_pkg::CELLS];
  logic [4:0]    cell_q;
  logic [IW-1:0] stk_q;

  logic          cell_we;
  logic [IW-1:0] cell_waddr;
  logic [4:0]    cell_wdata;
  logic          cell_re;
  logic [IW-1:0] cell_raddr;
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [IW-1:0] stk_wdata;

  gmb_pkg::cmd_t cmd;
  logic [15:0]   rnd;
  logic [CW-1:0] rx, ry;
  logic [DW-1:0] depth;
  logic [2:0]    exits;
  logic [IW-1:0] clr_cnt;
  logic [IW-1:0] top_idx;
  logic [2:0]    rcnt;
  logic [4:0]    nb_val [4];
  logic [4:0]    top_val;
  logic [1:0]    pick_d;

  logic [2:0]    res_stat;
  logic [CW-1:0] res_x, res_y;
  logic [4:0]    res_bits;

  logic          in_take, out_take;

  logic [CW-1:0] cx, cy;
  logic [SW-1:0] cx_w, cy_w;
  logic [3:0]    nb_ok;
  logic [CW-1:0] nb_x [4];
  logic [CW-1:0] nb_y [4];
  logic [3:0]    cand;
  logic [2:0]    cnt;
  logic [1:0]    sel;
  logic [1:0]    dsel;
  logic [2:0]    seen;
  logic [4:0]    top_clr, nb_clr;
  logic          xy_in;
  logic [4:0]    exit_bit;
  logic [4:0]    xy_new;

  assign side = (grid_side < SW'(2)) ? SW'(2) :
                (grid_side > SW'(gmb_pkg::MAX_SIDE)) ? SW'(gmb_pkg::MAX_SIDE) : grid_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side  <= SW'(16);
      exit_limit <= 3'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) exit_limit <= pwdata[2:0];
      else          grid_side  <= pwdata[SW-1:0];
    end
  end

  assign prdata = paddr[2] ? {29'd0, exit_limit} : {{(32-SW){1'b0}}, grid_side};

  assign in_stall = (ctl.op != gmb_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) cell_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[IW'(depth - DW'(1))];
  end

  assign cx   = top_idx[CW-1:0];
  assign cy   = top_idx[IW-1:CW];
  assign cx_w = SW'(cx);
  assign cy_w = SW'(cy);

  always_comb begin
    nb_x[gmb_pkg::DIR_DOWN]  = cx;        nb_y[gmb_pkg::DIR_DOWN]  = cy + CW'(1);
    nb_x[gmb_pkg::DIR_UP]    = cx;        nb_y[gmb_pkg::DIR_UP]    = cy - CW'(1);
    nb_x[gmb_pkg::DIR_RIGHT] = cx + CW'(1); nb_y[gmb_pkg::DIR_RIGHT] = cy;
    nb_x[gmb_pkg::DIR_LEFT]  = cx - CW'(1); nb_y[gmb_pkg::DIR_LEFT]  = cy;
    nb_ok[gmb_pkg::DIR_DOWN]  = (cx_w < side) && ((cy_w + SW'(1)) < side);
    nb_ok[gmb_pkg::DIR_UP]    = (cx_w < side) && (cy != '0) && (cy_w <= side);
    nb_ok[gmb_pkg::DIR_RIGHT] = (cy_w < side) && ((cx_w + SW'(1)) < side);
    nb_ok[gmb_pkg::DIR_LEFT]  = (cy_w < side) && (cx != '0) && (cx_w <= side);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) cand[i] = nb_ok[i] && !nb_val[i][4];
    cnt  = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
    sel  = gmb_pkg::mod_cnt(rnd, cnt);
    dsel = 2'd0;
    seen = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, sel}) dsel = 2'(i);
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    case (pick_d)
      gmb_pkg::DIR_DOWN:  begin top_clr = gmb_pkg::B_BOTTOM; nb_clr = gmb_pkg::B_TOP;    end
      gmb_pkg::DIR_UP:    begin top_clr = gmb_pkg::B_TOP;    nb_clr = gmb_pkg::B_BOTTOM; end
      gmb_pkg::DIR_RIGHT: begin top_clr = gmb_pkg::B_RIGHT;  nb_clr = gmb_pkg::B_LEFT;   end
      default:            begin top_clr = gmb_pkg::B_LEFT;   nb_clr = gmb_pkg::B_RIGHT;  end
    endcase
  end

  always_comb begin
    xy_in    = (SW'(rx) < side) && (SW'(ry) < side);
    exit_bit = 5'd0;
    if (exits < exit_limit) begin
      if (ry == '0)                         exit_bit = gmb_pkg::B_TOP;
      else if (SW'(ry) == side - SW'(1))    exit_bit = gmb_pkg::B_BOTTOM;
      else if (rx == '0)                    exit_bit = gmb_pkg::B_LEFT;
      else if (SW'(rx) == side - SW'(1))    exit_bit = gmb_pkg::B_RIGHT;
    end
    xy_new = cell_q & ~exit_bit;
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_cnt;
    cell_wdata = gmb_pkg::B_WALLS;
    cell_re    = 1'b0;
    cell_raddr = {ry, rx};
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    case (ctl.op)
      gmb_pkg::S_CLEAR: cell_we = 1'b1;
      gmb_pkg::S_CLEAR_END: begin
        cell_we    = 1'b1;
        cell_waddr = '0;
        cell_wdata = gmb_pkg::B_WALLS | gmb_pkg::B_VISIT;
        stk_we     = 1'b1;
      end
      gmb_pkg::S_NB_RD: begin
        cell_re = (rcnt < 3'd5);
        if (rcnt < 3'd4) cell_raddr = {nb_y[rcnt[1:0]], nb_x[rcnt[1:0]]};
        else             cell_raddr = top_idx;
      end
      gmb_pkg::S_CARVE_TOP: begin
        cell_we    = 1'b1;
        cell_waddr = top_idx;
        cell_wdata = top_val & ~top_clr;
      end
      gmb_pkg::S_CARVE_NB: begin
        cell_we    = 1'b1;
        cell_waddr = {nb_y[pick_d], nb_x[pick_d]};
        cell_wdata = (nb_val[pick_d] & ~nb_clr) | gmb_pkg::B_VISIT;
        stk_we     = (depth < DW'(gmb_pkg::CELLS));
        stk_waddr  = depth[IW-1:0];
        stk_wdata  = {nb_y[pick_d], nb_x[pick_d]};
      end
      gmb_pkg::S_XY_RD: cell_re = 1'b1;
      gmb_pkg::S_XY_EXEC: begin
        cell_we    = (cmd == gmb_pkg::CMD_EXIT) && xy_in && (exit_bit != 5'd0);
        cell_waddr = {ry, rx};
        cell_wdata = xy_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      exits <= '0;
      cmd   <= gmb_pkg::CMD_START;
    end else begin
      case (ctl.op)
        gmb_pkg::S_CLEAR_END: begin
          depth <= DW'(1);
          exits <= '0;
        end
        gmb_pkg::S_CARVE_NB: if (depth < DW'(gmb_pkg::CELLS)) depth <= depth + DW'(1);
        gmb_pkg::S_POP: depth <= depth - DW'(1);
        gmb_pkg::S_XY_EXEC:
          if (cell_we) exits <= exits + 3'd1;
        default: ;
      endcase
      if (in_take) cmd <= gmb_pkg::cmd_t'(command);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      gmb_pkg::S_IDLE: begin
        clr_cnt <= '0;
        if (in_take) begin
          rnd <= random_value;
          rx  <= cell_x;
          ry  <= cell_y;
        end
      end
      gmb_pkg::S_CLEAR: clr_cnt <= clr_cnt + IW'(1);
      gmb_pkg::S_CLEAR_END: begin
        res_stat <= gmb_pkg::ST_STARTED;
        res_x    <= '0;
        res_y    <= '0;
        res_bits <= gmb_pkg::B_WALLS | gmb_pkg::B_VISIT;
      end
      gmb_pkg::S_EMPTY: begin
        res_stat <= gmb_pkg::ST_FINISHED;
        res_x    <= '0;
        res_y    <= '0;
        res_bits <= '0;
      end
      gmb_pkg::S_STK_WAIT: begin
        top_idx <= stk_q;
        rcnt    <= 3'd0;
      end
      gmb_pkg::S_NB_RD: begin
        rcnt <= rcnt + 3'd1;
        if (rcnt == 3'd5)      top_val <= cell_q;
        else if (rcnt != 3'd0) nb_val[2'(rcnt - 3'd1)] <= cell_q;
      end
      gmb_pkg::S_PICK: pick_d <= dsel;
      gmb_pkg::S_CARVE_NB: begin
        res_stat <= gmb_pkg::ST_CARVED;
        res_x    <= nb_x[pick_d];
        res_y    <= nb_y[pick_d];
        res_bits <= (nb_val[pick_d] & ~nb_clr) | gmb_pkg::B_VISIT;
      end
      gmb_pkg::S_POP: begin
        res_stat <= gmb_pkg::ST_BACK;
        res_x    <= cx;
        res_y    <= cy;
        res_bits <= top_val;
      end
      gmb_pkg::S_XY_EXEC: begin
        res_x <= rx;
        res_y <= ry;
        if (cmd == gmb_pkg::CMD_READ) begin
          res_stat <= gmb_pkg::ST_READ;
          res_bits <= xy_in ? cell_q : 5'd0;
        end else if (!xy_in) begin
          res_stat <= gmb_pkg::ST_EXIT_NO;
          res_bits <= 5'd0;
        end else if (exit_bit == 5'd0) begin
          res_stat <= gmb_pkg::ST_EXIT_NO;
          res_bits <= cell_q;
        end else begin
          res_stat <= gmb_pkg::ST_EXIT_OK;
          res_bits <= xy_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == gmb_pkg::S_DONE && !out_valid) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == gmb_pkg::S_DONE && !out_valid) begin
      status       <= res_stat;
      pos_x        <= res_x;
      pos_y        <= res_y;
      wall_top     <= res_bits[0];
      wall_bottom  <= res_bits[1];
      wall_left    <= res_bits[2];
      wall_right   <= res_bits[3];
      cell_visited <= res_bits[4];
    end
  end

  assign sts.cmd        = gmb_pkg::cmd_t'(command);
  assign sts.in_take    = in_take;
  assign sts.depth_zero = (depth == '0);
  assign sts.clr_last   = &clr_cnt;
  assign sts.rd_last    = (rcnt == 3'd5);
  assign sts.has_nb     = (cnt != 3'd0);
  assign sts.out_free   = !out_valid;

endmodule

>>> sv/grid_maze_backtracker_unit.sv
// Per command: start runs a clear sweep over all 16384 cells; walk reads the
// stack top, then five serial reads on the single cell port, then carves the top
// and a neighbour or pops, or reports finished on an empty stack; exit and read
// read the cell, then execute. Throughput: one item at a time; the next item can
// be taken in the cycle after the result loads into the output register.
// Reset clears control, depth and exit count; cells are undefined until a start.
module grid_maze_backtracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] random_value,
  input  logic [6:0]  cell_x,
  input  logic [6:0]  cell_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [6:0]  pos_x,
  output logic [6:0]  pos_y,
  output logic        wall_top,
  output logic        wall_bottom,
  output logic        wall_left,
  output logic        wall_right,
  output logic        cell_visited
);

  gmb_pkg::ctl_t ctl;
  gmb_pkg::sts_t sts;

  assign pready = 1'b1;

  gmb_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  gmb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .random_value (random_value),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .wall_top     (wall_top),
    .wall_bottom  (wall_bottom),
    .wall_left    (wall_left),
    .wall_right   (wall_right),
    .cell_visited (cell_visited)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;

  typedef struct {
    gmb_pkg::cmd_t cmd;
    logic [15:0]   rnd;
    logic [6:0]    x;
    logic [6:0]    y;
  } maze_cmd_t;

  typedef struct {
    gmb_pkg::stat_t st;
    logic [6:0]     x;
    logic [6:0]     y;
    logic [4:0]     bits;
  } maze_rsp_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_stall;
  logic [1:0]  command;
  logic [15:0] random_value;
  logic [6:0]  cell_x, cell_y;
  logic        out_valid, out_stall;
  logic [2:0]  status;
  logic [6:0]  pos_x, pos_y;
  logic        wall_top, wall_bottom, wall_left, wall_right, cell_visited;

  grid_maze_backtracker_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .random_value(random_value), .cell_x(cell_x), .cell_y(cell_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .pos_x(pos_x), .pos_y(pos_y),
    .wall_top(wall_top), .wall_bottom(wall_bottom), .wall_left(wall_left),
    .wall_right(wall_right), .cell_visited(cell_visited)
  );

  maze_cmd_t pending_cmds[$];
  maze_rsp_t expected_rsps[$];
  maze_cmd_t driven_cmd;
  int        fail_count;

  logic [4:0]  maze_cells[gmb_pkg::CELLS];
  logic [13:0] path_stack[gmb_pkg::CELLS];
  int unsigned path_depth;
  int unsigned exit_count;
  logic [7:0]  side_reg;
  logic [2:0]  limit_reg;

  bit sender_hold;
  bit long_hold_req;
  int burst_left, gap_left;
  int hold_left, stall_pct, pattern_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned side_eff();
    if (side_reg < 8'd2) return 2;
    if (side_reg > 8'd128) return 128;
    return side_reg;
  endfunction

  function automatic maze_rsp_t make_rsp(gmb_pkg::stat_t st, int unsigned x, int unsigned y,
                                         logic [4:0] bits);
    maze_rsp_t r;
    r.st = st;
    r.x = x[6:0];
    r.y = y[6:0];
    r.bits = bits;
    return r;
  endfunction

  function automatic maze_rsp_t carve_step(logic [15:0] rnd);
    int dx[4];
    int dy[4];
    int unsigned s, top, cx, cy, cnt, ni, nx, ny;
    int pick[4];
    int tx, ty;
    gmb_pkg::dir_t d;
    dx = '{0, 0, 1, -1};
    dy = '{1, -1, 0, 0};
    s = side_eff();
    cnt = 0;
    if (path_depth == 0) return make_rsp(gmb_pkg::ST_FINISHED, 0, 0, 5'd0);
    top = path_stack[path_depth - 1];
    cx = top % gmb_pkg::MAX_SIDE;
    cy = top / gmb_pkg::MAX_SIDE;
    for (int i = 0; i < 4; i++) begin
      tx = int'(cx) + dx[i];
      ty = int'(cy) + dy[i];
      if (tx >= 0 && ty >= 0 && tx < int'(s) && ty < int'(s))
        if (!(maze_cells[ty * gmb_pkg::MAX_SIDE + tx] & gmb_pkg::B_VISIT)) begin
          pick[cnt] = i;
          cnt++;
        end
    end
    if (cnt == 0) begin
      path_depth--;
      return make_rsp(gmb_pkg::ST_BACK, cx, cy, maze_cells[top]);
    end
    d = gmb_pkg::dir_t'(pick[rnd % cnt]);
    nx = int'(cx) + dx[d];
    ny = int'(cy) + dy[d];
    ni = ny * gmb_pkg::MAX_SIDE + nx;
    case (d)
      gmb_pkg::DIR_RIGHT: begin
        maze_cells[top] &= ~gmb_pkg::B_RIGHT;
        maze_cells[ni] &= ~gmb_pkg::B_LEFT;
      end
      gmb_pkg::DIR_LEFT: begin
        maze_cells[top] &= ~gmb_pkg::B_LEFT;
        maze_cells[ni] &= ~gmb_pkg::B_RIGHT;
      end
      gmb_pkg::DIR_DOWN: begin
        maze_cells[top] &= ~gmb_pkg::B_BOTTOM;
        maze_cells[ni] &= ~gmb_pkg::B_TOP;
      end
      default: begin
        maze_cells[top] &= ~gmb_pkg::B_TOP;
        maze_cells[ni] &= ~gmb_pkg::B_BOTTOM;
      end
    endcase
    maze_cells[ni] |= gmb_pkg::B_VISIT;
    if (path_depth < gmb_pkg::CELLS) begin
      path_stack[path_depth] = ni[13:0];
      path_depth++;
    end
    return make_rsp(gmb_pkg::ST_CARVED, nx, ny, maze_cells[ni]);
  endfunction

  function automatic maze_rsp_t open_exit(int unsigned x, int unsigned y);
    int unsigned s, idx;
    logic [4:0] bit_sel;
    s = side_eff();
    bit_sel = 5'd0;
    if (x >= s || y >= s) return make_rsp(gmb_pkg::ST_EXIT_NO, x, y, 5'd0);
    idx = y * gmb_pkg::MAX_SIDE + x;
    if (exit_count < limit_reg) begin
      if (y == 0) bit_sel = gmb_pkg::B_TOP;
      else if (y == s - 1) bit_sel = gmb_pkg::B_BOTTOM;
      else if (x == 0) bit_sel = gmb_pkg::B_LEFT;
      else if (x == s - 1) bit_sel = gmb_pkg::B_RIGHT;
    end
    if (bit_sel == 5'd0) return make_rsp(gmb_pkg::ST_EXIT_NO, x, y, maze_cells[idx]);
    maze_cells[idx] &= ~bit_sel;
    exit_count = (exit_count + 1) & 7;
    return make_rsp(gmb_pkg::ST_EXIT_OK, x, y, maze_cells[idx]);
  endfunction

  function automatic maze_rsp_t maze_predict(maze_cmd_t c);
    int unsigned s;
    case (c.cmd)
      gmb_pkg::CMD_START: begin
        for (int i = 0; i < gmb_pkg::CELLS; i++) maze_cells[i] = gmb_pkg::B_WALLS;
        maze_cells[0] |= gmb_pkg::B_VISIT;
        path_stack[0] = '0;
        path_depth = 1;
        exit_count = 0;
        return make_rsp(gmb_pkg::ST_STARTED, 0, 0, maze_cells[0]);
      end
      gmb_pkg::CMD_WALK: return carve_step(c.rnd);
      gmb_pkg::CMD_EXIT: return open_exit(c.x, c.y);
      default: begin
        s = side_eff();
        if (c.x >= s || c.y >= s) return make_rsp(gmb_pkg::ST_READ, c.x, c.y, 5'd0);
        return make_rsp(gmb_pkg::ST_READ, c.x, c.y,
                        maze_cells[c.y * gmb_pkg::MAX_SIDE + c.x]);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_rsps.insert(expected_rsps.size(), maze_predict(driven_cmd));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !sender_hold) begin
          driven_cmd = pending_cmds.pop_front();
          command <= driven_cmd.cmd;
          random_value <= driven_cmd.rnd;
          cell_x <= driven_cmd.x;
          cell_y <= driven_cmd.y;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    maze_rsp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_pct = 0;
      pattern_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected item, status", status, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
          if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
          if (wall_top !== ((want.bits & gmb_pkg::B_TOP) != 0))
            report_mismatch("wall_top", wall_top, (want.bits & gmb_pkg::B_TOP) != 0);
          if (wall_bottom !== ((want.bits & gmb_pkg::B_BOTTOM) != 0))
            report_mismatch("wall_bottom", wall_bottom,
                            (want.bits & gmb_pkg::B_BOTTOM) != 0);
          if (wall_left !== ((want.bits & gmb_pkg::B_LEFT) != 0))
            report_mismatch("wall_left", wall_left, (want.bits & gmb_pkg::B_LEFT) != 0);
          if (wall_right !== ((want.bits & gmb_pkg::B_RIGHT) != 0))
            report_mismatch("wall_right", wall_right, (want.bits & gmb_pkg::B_RIGHT) != 0);
          if (cell_visited !== ((want.bits & gmb_pkg::B_VISIT) != 0))
            report_mismatch("cell_visited", cell_visited,
                            (want.bits & gmb_pkg::B_VISIT) != 0);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = 400;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(200, 20);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic add_cmd(gmb_pkg::cmd_t c, int unsigned rnd, int unsigned x, int unsigned y);
    maze_cmd_t m;
    m.cmd = c;
    m.rnd = rnd[15:0];
    m.x = x[6:0];
    m.y = y[6:0];
    pending_cmds.insert(pending_cmds.size(), m);
  endtask

  task automatic add_border_exit();
    int unsigned s, t;
    s = side_eff();
    t = $urandom_range(s - 1);
    case ($urandom_range(3))
      0: add_cmd(gmb_pkg::CMD_EXIT, $urandom, t, 0);
      1: add_cmd(gmb_pkg::CMD_EXIT, $urandom, t, s - 1);
      2: add_cmd(gmb_pkg::CMD_EXIT, $urandom, 0, t);
      default: add_cmd(gmb_pkg::CMD_EXIT, $urandom, s - 1, t);
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_rsps.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) side_reg = data[7:0];
    else limit_reg = data[2:0];
  endtask

  initial begin
    int sides[7];
    int limits[7];
    int unsigned s, r;
    sides = '{16, 2, 0, 255, 5, 128, 7};
    limits = '{1, 0, 4, 7, 3, 2, 4};
    fail_count = 0;
    side_reg = 8'd16;
    limit_reg = 3'd1;
    path_depth = 0;
    exit_count = 0;
    sender_hold = 0;
    long_hold_req = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    out_stall <= 1'b0;
    command <= gmb_pkg::CMD_WALK;
    random_value <= '0;
    cell_x <= '0;
    cell_y <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_cmd(gmb_pkg::CMD_WALK, 16'hFFFF, 127, 127);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 127, 127);
    add_cmd(gmb_pkg::CMD_READ, 0, 127, 64);
    add_cmd(gmb_pkg::CMD_START, 16'hFFFF, 127, 127);
    add_cmd(gmb_pkg::CMD_READ, 0, 0, 0);
    add_cmd(gmb_pkg::CMD_WALK, 0, 0, 0);
    add_cmd(gmb_pkg::CMD_WALK, 16'hFFFF, 0, 0);
    add_cmd(gmb_pkg::CMD_WALK, 16'h5555, 0, 0);
    add_cmd(gmb_pkg::CMD_WALK, 16'hAAAA, 0, 0);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 5, 5);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 3, 0);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 4, 15);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 16, 3);
    add_cmd(gmb_pkg::CMD_READ, 0, 3, 0);
    add_cmd(gmb_pkg::CMD_READ, 0, 15, 15);
    add_cmd(gmb_pkg::CMD_READ, 0, 16, 0);
    drain();
    cfg_write(3'd4, 32'd4);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 0, 0);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 15, 15);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 0, 7);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 15, 7);
    add_cmd(gmb_pkg::CMD_EXIT, 0, 0, 7);
    add_cmd(gmb_pkg::CMD_READ, 0, 15, 7);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        cfg_write(3'd0, 32'(sides[p]));
        cfg_write(3'd4, 32'(limits[p]));
      end
      if (p != 3 && p != 6) add_cmd(gmb_pkg::CMD_START, $urandom, $urandom, $urandom);
      s = side_eff();
      for (int i = 0; i < 68; i++) begin
        r = $urandom_range(99);
        if (r < 1) add_cmd(gmb_pkg::CMD_START, $urandom, $urandom, $urandom);
        else if (r < 62) add_cmd(gmb_pkg::CMD_WALK, $urandom, $urandom, $urandom);
        else if (r < 75) add_border_exit();
        else if (r < 80)
          add_cmd(gmb_pkg::CMD_EXIT, $urandom, $urandom_range(127), $urandom_range(127));
        else if (r < 94)
          add_cmd(gmb_pkg::CMD_READ, $urandom, $urandom_range(s - 1), $urandom_range(s - 1));
        else
          add_cmd(gmb_pkg::CMD_READ, $urandom, $urandom_range(127), $urandom_range(127));
      end
      if (p == 2) begin
        @(negedge clk);
        long_hold_req = 1;
      end
      if (p == 4) begin
        repeat (20) @(negedge clk);
        sender_hold = 1;
        while (in_valid || expected_rsps.size() > 0) @(negedge clk);
        sender_hold = 0;
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
